// ----- src/trms_pkg.sv -----
`default_nettype none
package trms_pkg;

	localparam int QUEUE_FRAMES = 4;
	localparam int MAX_PAYLOAD  = 32;
	localparam int STATIONS     = 15;
	localparam int SLOT_BYTES   = MAX_PAYLOAD + 4;
	localparam int STORE_BYTES  = QUEUE_FRAMES * SLOT_BYTES;

	localparam int QADDR_W = $clog2(STORE_BYTES);
	localparam int RADDR_W = $clog2(SLOT_BYTES);
	localparam int QIDX_W  = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
	localparam int FILL_W  = $clog2(QUEUE_FRAMES + 1);
	localparam int SIDX_W  = $clog2(STATIONS);
	localparam int TOKK_W  = $clog2(STATIONS + 1);
	localparam int POS_W   = 6;
	localparam int LEN_W   = 6;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [2:0] FN_NEW_TOKEN = 3'd0;
	localparam logic [2:0] FN_START     = 3'd1;
	localparam logic [2:0] FN_STOP      = 3'd2;
	localparam logic [2:0] FN_DATA_IND  = 3'd3;
	localparam logic [2:0] FN_TOKEN     = 3'd4;
	localparam logic [2:0] FN_RETURNED  = 3'd5;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_CHANGE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] CFG_STATION_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_TOKEN_TAG       = 2'd1;
	localparam logic [1:0] CFG_TIME_SERVICE    = 2'd2;

	localparam logic [7:0] CHAT_BIT  = 8'h02;
	localparam logic [7:0] CHAT_MASK = 8'hFD;
	localparam logic [7:0] ACK_MASK  = 8'hFC;
	localparam logic [1:0] ACK_BITS  = 2'b11;
	localparam logic [3:0] BROADCAST = 4'hF;

	localparam logic [2:0] HDR_LAST = 3'd4;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_HDR   = 12'b0000_0000_0010,
		ST_TOK   = 12'b0000_0000_0100,
		ST_NOTE  = 12'b0000_0000_1000,
		ST_QRD   = 12'b0000_0001_0000,
		ST_QEM   = 12'b0000_0010_0000,
		ST_RRD2  = 12'b0000_0100_0000,
		ST_RRD1  = 12'b0000_1000_0000,
		ST_RSTAT = 12'b0001_0000_0000,
		ST_RDEC  = 12'b0010_0000_0000,
		ST_RRD   = 12'b0100_0000_0000,
		ST_REM   = 12'b1000_0000_0000
	} trms_state_t;

	function automatic logic [QADDR_W-1:0] slot_base(input logic [QIDX_W-1:0] slot);
		slot_base = QADDR_W'(slot) * QADDR_W'(SLOT_BYTES);
	endfunction

endpackage
`default_nettype wire

// ----- src/token_ring_mac_sender_top.sv -----
`default_nettype none
// channel  handshake                payload
// in       in_valid / in_stall      func, data_byte, dest_address, service_id, last
// out      out_valid / out_stall    out_kind, out_byte, out_last
// cfg      cfg_we                   cfg_index, cfg_data
// one item at a time; in_stall is low only while idle. a closing data item writes
// the header in ST_HDR if a queue slot is free; tokens and notices give one result
// a cycle unless stalled; queued and resent frames go a byte at a time through a
// frame memory read port; a returned frame is decided in ST_RRD2 through ST_RDEC
// reset clears the queue pointers, service list and counters; frame memories need none
// results wait in one output register while out_stall is high
module token_ring_mac_sender_top
	import trms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] func,
	input  wire logic [7:0] data_byte,
	input  wire logic [3:0] dest_address,
	input  wire logic [2:0] service_id,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [1:0] out_kind,
	output logic      [7:0] out_byte,
	output logic            out_last,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	trms_state_t st_q;

	logic [3:0] sa_q;
	logic [7:0] tag_q;
	logic [2:0] tsb_q;

	logic [7:0]        ss_q [STATIONS];
	logic [LEN_W-1:0]  len_q [QUEUE_FRAMES];
	logic              chat_q, chg_q, pend_q, fresh_q;
	logic [1:0]        rc_q;
	logic [QIDX_W-1:0] head_q, tail_q;
	logic [FILL_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q, cnt_q;
	logic [7:0]        sum_q, dl_q;
	logic [3:0]        dest_q, daddr_q;
	logic [2:0]        sid_q, wstep_q;
	logic [TOKK_W-1:0] k_q;
	logic [1:0]        note_q;

	logic              out_valid_q, out_last_q;
	logic [1:0]        out_kind_q;
	logic [7:0]        out_byte_q;

	logic acc, free;
	assign acc  = in_valid && (st_q == ST_IDLE);
	assign free = !out_valid_q || !out_stall;

	// service list read port
	logic [SIDX_W-1:0] ss_idx, tok_i;
	logic [7:0]        ss_rd;
	assign tok_i = SIDX_W'(k_q - 1'b1);
	always_comb begin
		if (st_q == ST_TOK) begin
			ss_idx = tok_i;
		end else if (func == FN_START || func == FN_STOP) begin
			ss_idx = SIDX_W'(sa_q);
		end else begin
			ss_idx = SIDX_W'(pos_q - 1'b1);
		end
		ss_rd = (32'(ss_idx) < STATIONS) ? ss_q[ss_idx] : 8'h00;
	end

	logic sa_in;
	assign sa_in = 32'(sa_q) < STATIONS;

	// payload step
	logic             pay_take, qfree;
	logic [POS_W-1:0] pos_inc, pos_sat;
	logic [7:0]       sum_n;
	assign qfree    = 32'(fill_q) < QUEUE_FRAMES;
	assign pay_take = !pend_q && data_byte != 8'h00 && 32'(pos_q) < MAX_PAYLOAD - 1;
	assign pos_inc  = pos_q + 1'b1;
	assign pos_sat  = (pos_q != POS_MAX) ? pos_inc : pos_q;
	assign sum_n    = sum_q + data_byte;

	logic list_hit, chg_n;
	assign list_hit = pos_q != '0 && 32'(pos_q) <= STATIONS && ss_rd != data_byte;
	assign chg_n    = chg_q || list_hit;

	// header and trailer bytes; a count pushed up by other kinds is capped
	logic [POS_W-1:0] pos_hdr;
	logic [7:0] c1, c2, hlen, hsum;
	assign pos_hdr = (32'(pos_q) > MAX_PAYLOAD - 1) ? POS_W'(MAX_PAYLOAD - 1) : pos_q;
	assign c1   = {1'b0, sa_q, sid_q};
	assign c2   = {1'b0, dest_q, sid_q};
	assign hlen = 8'(pos_hdr) + 8'd1;
	assign hsum = sum_q + c1 + c2 + hlen;

	// frame queue memory
	logic               q_we;
	logic [QADDR_W-1:0] q_waddr, q_raddr, tail_base;
	logic [7:0]         q_wdata, q_rdata;
	assign tail_base = slot_base(tail_q);
	assign q_raddr   = slot_base(head_q) + QADDR_W'(cnt_q);

	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_base + QADDR_W'(3) + QADDR_W'(pos_q);
		q_wdata = data_byte;
		if (st_q == ST_HDR) begin
			q_we = 1'b1;
			unique case (wstep_q)
				3'd0: begin
					q_waddr = tail_base;
					q_wdata = c1;
				end
				3'd1: begin
					q_waddr = tail_base + QADDR_W'(1);
					q_wdata = c2;
				end
				3'd2: begin
					q_waddr = tail_base + QADDR_W'(2);
					q_wdata = hlen;
				end
				3'd3: begin
					q_waddr = tail_base + QADDR_W'(3) + QADDR_W'(pos_hdr);
					q_wdata = 8'h00;
				end
				default: begin
					q_waddr = tail_base + QADDR_W'(4) + QADDR_W'(pos_hdr);
					q_wdata = {hsum[5:0], 2'b00};
				end
			endcase
		end else if (acc && func == FN_DATA_IND && pay_take && qfree) begin
			q_we = 1'b1;
		end
	end

	trms_ram #(.DEPTH(STORE_BYTES), .WIDTH(8)) u_qmem (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// returned frame memory
	logic               r_we;
	logic [RADDR_W-1:0] r_waddr, r_raddr, stat_addr;
	logic [7:0]         r_wdata, r_rdata, status;
	logic               fits, resend;
	assign stat_addr = RADDR_W'(dl_q + 8'd3);
	assign fits      = 32'(dl_q) <= MAX_PAYLOAD;
	assign status    = fits ? r_rdata : 8'h03;
	assign resend    = fits && status[1:0] != ACK_BITS && rc_q < 2'd2 && daddr_q != BROADCAST;

	always_comb begin
		priority case (1'b1)
			st_q == ST_RRD2:  r_raddr = RADDR_W'(2);
			st_q == ST_RRD1:  r_raddr = RADDR_W'(1);
			st_q == ST_RSTAT: r_raddr = stat_addr;
			default:          r_raddr = RADDR_W'(cnt_q);
		endcase
		if (st_q == ST_RDEC) begin
			r_we    = resend;
			r_waddr = stat_addr;
			r_wdata = status & ACK_MASK;
		end else begin
			r_we    = acc && func == FN_RETURNED && 32'(pos_q) < SLOT_BYTES;
			r_waddr = RADDR_W'(pos_q);
			r_wdata = data_byte;
		end
	end

	trms_ram #(.DEPTH(SLOT_BYTES), .WIDTH(8)) u_rmem (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	// token byte
	logic [7:0] own, tok_byte;
	always_comb begin
		own = 8'(1) << tsb_q;
		if (fresh_q || chat_q) begin
			own = own | CHAT_BIT;
		end
		if (k_q == '0) begin
			tok_byte = tag_q;
		end else if (4'(tok_i) == sa_q) begin
			tok_byte = own;
		end else begin
			tok_byte = fresh_q ? 8'h00 : ss_rd;
		end
	end

	// result load
	logic       ld, ld_last;
	logic [1:0] ld_kind;
	logic [7:0] ld_byte;
	logic [LEN_W-1:0] qlen;
	assign qlen = len_q[head_q];
	always_comb begin
		ld      = 1'b0;
		ld_kind = KIND_BYTE;
		ld_byte = 8'h00;
		ld_last = 1'b0;
		priority case (1'b1)
			st_q == ST_TOK: begin
				ld      = free;
				ld_byte = tok_byte;
				ld_last = 32'(k_q) == STATIONS;
			end
			st_q == ST_NOTE: begin
				ld      = free;
				ld_kind = note_q;
			end
			st_q == ST_QEM: begin
				ld      = free;
				ld_byte = q_rdata;
				ld_last = cnt_q == qlen - 1'b1;
			end
			st_q == ST_REM: begin
				ld      = free;
				ld_byte = r_rdata;
				ld_last = cnt_q == POS_W'(stat_addr);
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_kind_q <= ld_kind;
			out_byte_q <= ld_byte;
			out_last_q <= ld_last;
		end
	end

	// frame lengths per slot
	always_ff @(posedge clk) begin
		if (st_q == ST_HDR && wstep_q == HDR_LAST) begin
			len_q[tail_q] <= LEN_W'(pos_hdr) + LEN_W'(5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q  <= 4'd1;
			tag_q <= 8'hFF;
			tsb_q <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STATION_ADDRESS: sa_q  <= cfg_data[3:0];
				CFG_TOKEN_TAG:       tag_q <= cfg_data;
				CFG_TIME_SERVICE:    tsb_q <= cfg_data[2:0];
				default:             sa_q  <= sa_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			for (int i = 0; i < STATIONS; i++) begin
				ss_q[i] <= 8'h00;
			end
			chat_q  <= 1'b0;
			chg_q   <= 1'b0;
			pend_q  <= 1'b0;
			fresh_q <= 1'b0;
			rc_q    <= 2'd0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= 8'h00;
			dl_q    <= 8'h00;
			dest_q  <= 4'h0;
			daddr_q <= 4'h0;
			sid_q   <= 3'd0;
			wstep_q <= 3'd0;
			k_q     <= '0;
			note_q  <= KIND_CHANGE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (func)
							FN_NEW_TOKEN: begin
								k_q     <= '0;
								fresh_q <= 1'b1;
								st_q    <= ST_TOK;
							end
							FN_START: begin
								chat_q <= 1'b1;
								if (sa_in) begin
									ss_q[ss_idx] <= ss_rd | CHAT_BIT;
								end
							end
							FN_STOP: begin
								chat_q <= 1'b0;
								if (sa_in) begin
									ss_q[ss_idx] <= ss_rd & CHAT_MASK;
								end
							end
							FN_DATA_IND: begin
								if (pay_take) begin
									pos_q <= pos_inc;
									sum_q <= sum_n;
								end
								if (!pend_q && data_byte == 8'h00) begin
									pend_q <= 1'b1;
								end
								if (last && qfree) begin
									dest_q  <= dest_address;
									sid_q   <= service_id;
									wstep_q <= 3'd0;
									st_q    <= ST_HDR;
								end
							end
							FN_TOKEN: begin
								if (list_hit) begin
									ss_q[ss_idx] <= data_byte;
								end
								pos_q <= pos_sat;
								chg_q <= chg_n;
								if (last) begin
									chg_q <= 1'b0;
									if (chg_n) begin
										note_q <= KIND_CHANGE;
										st_q   <= ST_NOTE;
									end else begin
										cnt_q   <= '0;
										k_q     <= '0;
										fresh_q <= 1'b0;
										st_q    <= (fill_q != '0) ? ST_QRD : ST_TOK;
									end
								end
							end
							FN_RETURNED: begin
								pos_q <= pos_sat;
								if (last) begin
									st_q <= ST_RRD2;
								end
							end
							default: begin
								pos_q <= pos_q;
							end
						endcase
						// end of event, except for a data frame still being closed
						if (last && !(func == FN_DATA_IND && qfree)) begin
							pos_q  <= '0;
							sum_q  <= 8'h00;
							pend_q <= 1'b0;
						end
					end
				end
				ST_HDR: begin
					wstep_q <= wstep_q + 3'd1;
					if (wstep_q == HDR_LAST) begin
						tail_q <= (32'(tail_q) == QUEUE_FRAMES - 1) ? '0 : tail_q + 1'b1;
						fill_q <= fill_q + 1'b1;
						pos_q  <= '0;
						sum_q  <= 8'h00;
						pend_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				ST_TOK: begin
					if (free) begin
						k_q <= k_q + 1'b1;
						if (32'(k_q) == STATIONS) begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_NOTE: begin
					if (free) begin
						cnt_q   <= '0;
						k_q     <= '0;
						fresh_q <= 1'b0;
						st_q    <= (fill_q != '0) ? ST_QRD : ST_TOK;
					end
				end
				ST_QRD: begin
					st_q <= ST_QEM;
				end
				ST_QEM: begin
					if (free) begin
						if (ld_last) begin
							head_q <= (32'(head_q) == QUEUE_FRAMES - 1) ? '0 : head_q + 1'b1;
							fill_q <= fill_q - 1'b1;
							st_q   <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							st_q  <= ST_QRD;
						end
					end
				end
				ST_RRD2: begin
					st_q <= ST_RRD1;
				end
				ST_RRD1: begin
					dl_q <= r_rdata;
					st_q <= ST_RSTAT;
				end
				ST_RSTAT: begin
					daddr_q <= r_rdata[6:3];
					st_q    <= ST_RDEC;
				end
				ST_RDEC: begin
					if (resend) begin
						rc_q  <= rc_q + 2'd1;
						cnt_q <= '0;
						st_q  <= ST_RRD;
					end else begin
						rc_q <= 2'd0;
						if (rc_q == 2'd2) begin
							note_q <= KIND_ERROR;
							st_q   <= ST_NOTE;
						end else begin
							cnt_q   <= '0;
							k_q     <= '0;
							fresh_q <= 1'b0;
							st_q    <= (fill_q != '0) ? ST_QRD : ST_TOK;
						end
					end
				end
				ST_RRD: begin
					st_q <= ST_REM;
				end
				ST_REM: begin
					if (free) begin
						if (ld_last) begin
							st_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							st_q  <= ST_RRD;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = st_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// ----- src/trms_ram.sv -----
`default_nettype none
module trms_ram #(
	parameter int DEPTH  = 36,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import trms_pkg::*;

	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int PHASE_ITEMS = 24;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       fin;
	} txres_t;

	typedef struct packed {
		logic [2:0] fn;
		logic [7:0] b;
		logic [3:0] dest;
		logic [2:0] sid;
		logic       lst;
	} item_t;

	typedef struct packed {
		item_t      it;
		logic       typed;
		logic [1:0] wkind;
		logic [7:0] wbyte;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] func = '0;
	logic [7:0] data_byte = '0;
	logic [3:0] dest_address = '0;
	logic [2:0] service_id = '0;
	logic last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic out_last;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	token_ring_mac_sender_top dut (.*);

	always #5 clk = ~clk;

	// shadow of the transmitter
	logic [3:0] own_addr;
	logic [7:0] tok_tag;
	logic [2:0] time_bit;
	logic [7:0] svc_list [STATIONS];
	bit chat_on, list_dirty, text_done;
	int resends, q_head, q_tail, q_fill, byte_pos, csum;
	logic [7:0] frame_store [QUEUE_FRAMES*SLOT_BYTES];
	int frame_len [QUEUE_FRAMES];
	logic [7:0] echo_frame [SLOT_BYTES];

	txres_t fresh[$];
	txres_t awaited[$];
	int errors = 0;
	int gap_pct = 30, stall_pct = 30;
	bit squeeze = 0;

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void put(input logic [1:0] k, input logic [7:0] b);
		fresh.push_back('{k, b, 1'b0});
	endfunction

	function automatic void token_out(input bit is_new);
		logic [7:0] b;
		put(KIND_BYTE, tok_tag);
		for (int i = 0; i < STATIONS; i++) begin
			b = is_new ? 8'h00 : svc_list[i];
			if (i == own_addr) begin
				b = 8'h01 << time_bit;
				if (is_new || chat_on)
					b |= CHAT_BIT;
			end
			put(KIND_BYTE, b);
		end
	endfunction

	function automatic void queue_out();
		int n;
		if (q_fill > 0) begin
			n = frame_len[q_head];
			if (n > SLOT_BYTES)
				n = SLOT_BYTES;
			for (int i = 0; i < n; i++)
				put(KIND_BYTE, frame_store[q_head*SLOT_BYTES + i]);
			q_head = (q_head + 1) % QUEUE_FRAMES;
			q_fill--;
		end else begin
			token_out(0);
		end
	endfunction

	function automatic void transmit_step(input item_t it);
		int p, base, dl, sum;
		logic [7:0] c1, c2, stat;
		bit fits;
		fresh.delete();
		case (it.fn)
			FN_NEW_TOKEN: token_out(1);
			FN_START: begin
				chat_on = 1;
				if (own_addr < STATIONS)
					svc_list[own_addr] |= CHAT_BIT;
			end
			FN_STOP: begin
				chat_on = 0;
				if (own_addr < STATIONS)
					svc_list[own_addr] &= CHAT_MASK;
			end
			FN_DATA_IND: begin
				if (!text_done) begin
					if (it.b == 0) begin
						text_done = 1;
					end else if (byte_pos < MAX_PAYLOAD - 1) begin
						if (q_fill < QUEUE_FRAMES)
							frame_store[q_tail*SLOT_BYTES + 3 + byte_pos] = it.b;
						csum = (csum + it.b) & 8'hFF;
						byte_pos++;
					end
				end
				if (it.lst && q_fill < QUEUE_FRAMES) begin
					p = byte_pos > MAX_PAYLOAD - 1 ? MAX_PAYLOAD - 1 : byte_pos;
					base = q_tail * SLOT_BYTES;
					c1 = {own_addr[3:0], 3'b000} | it.sid;
					c2 = {it.dest[3:0], 3'b000} | it.sid;
					frame_store[base] = c1;
					frame_store[base + 1] = c2;
					frame_store[base + 2] = 8'(p + 1);
					frame_store[base + 3 + p] = 8'h00;
					sum = (csum + c1 + c2 + p + 1) & 8'hFF;
					frame_store[base + 4 + p] = 8'(sum << 2);
					frame_len[q_tail] = p + 5;
					q_tail = (q_tail + 1) % QUEUE_FRAMES;
					q_fill++;
				end
			end
			FN_TOKEN: begin
				if (byte_pos >= 1 && byte_pos <= STATIONS) begin
					if (svc_list[byte_pos-1] != it.b) begin
						svc_list[byte_pos-1] = it.b;
						list_dirty = 1;
					end
				end
				if (byte_pos < 63)
					byte_pos++;
				if (it.lst) begin
					if (list_dirty)
						put(KIND_CHANGE, 8'h00);
					list_dirty = 0;
					queue_out();
				end
			end
			FN_RETURNED: begin
				if (byte_pos < SLOT_BYTES)
					echo_frame[byte_pos] = it.b;
				if (byte_pos < 63)
					byte_pos++;
				if (it.lst) begin
					dl = echo_frame[2];
					fits = dl + 4 <= SLOT_BYTES;
					stat = fits ? echo_frame[dl+3] : 8'h03;
					if (fits && stat[1:0] != ACK_BITS && resends < 2
							&& echo_frame[1][6:3] != BROADCAST) begin
						resends++;
						echo_frame[dl+3] = stat & ACK_MASK;
						for (int i = 0; i < dl + 4; i++)
							put(KIND_BYTE, echo_frame[i]);
					end else begin
						if (resends == 2)
							put(KIND_ERROR, 8'h00);
						resends = 0;
						queue_out();
					end
				end
			end
			default: ;
		endcase
		if (it.lst) begin
			byte_pos = 0;
			csum = 0;
			text_done = 0;
		end
		if (fresh.size() > 0)
			fresh[fresh.size()-1].fin = 1;
	endfunction

	function automatic int pick_gap(input int pct);
		int r;
		r = $urandom_range(0, 99);
		if (r >= pct)
			return 0;
		if (r < pct / 8)
			return $urandom_range(5, 30);
		return $urandom_range(1, 3);
	endfunction

	task automatic send(input item_t it);
		int g;
		g = pick_gap(gap_pct);
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		func <= it.fn;
		data_byte <= it.b;
		dest_address <= it.dest;
		service_id <= it.sid;
		last <= it.lst;
		do @(posedge clk); while (in_stall);
		transmit_step(it);
		foreach (fresh[i])
			awaited.push_back(fresh[i]);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (awaited.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		case (idx)
			CFG_STATION_ADDRESS: own_addr = v[3:0];
			CFG_TOKEN_TAG: tok_tag = v;
			CFG_TIME_SERVICE: time_bit = v[2:0];
			default: ;
		endcase
	endtask

	function automatic item_t mk(input logic [2:0] f, input logic [7:0] b, input bit l);
		return '{f, b, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), l};
	endfunction

	// one random event, returns the number of items that count
	task automatic random_event(output int cnt);
		int sel, n, dl, reps;
		bit changed;
		item_t seq[$];
		logic [7:0] st;
		sel = $urandom_range(0, 99);
		cnt = 0;
		if (sel < 35) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
			for (int i = 0; i < n; i++)
				seq.push_back(mk(FN_DATA_IND,
					($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)), 0));
			seq.push_back(mk(FN_DATA_IND, 8'($urandom_range(0, 255)), 1));
		end else if (sel < 55) begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : STATIONS + 1;
			changed = $urandom_range(0, 2) == 0;
			seq.push_back(mk(FN_TOKEN, tok_tag, n == 1));
			for (int i = 1; i < n; i++)
				seq.push_back(mk(FN_TOKEN,
					(changed && $urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
					: (i <= STATIONS ? svc_list[i-1] : 8'($urandom_range(0, 255))),
					i == n - 1));
		end else if (sel < 75) begin
			dl = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 255) : $urandom_range(0, 32);
			st = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				st[1:0] = ACK_BITS;
			seq.push_back(mk(FN_RETURNED, 8'($urandom_range(0, 255)), 0));
			seq.push_back(mk(FN_RETURNED, {1'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0) ? BROADCAST : 4'($urandom_range(0, 15)),
				3'($urandom_range(0, 7))}, 0));
			seq.push_back(mk(FN_RETURNED, 8'(dl), 0));
			n = dl <= MAX_PAYLOAD ? dl : $urandom_range(0, 40);
			for (int i = 0; i < n; i++)
				seq.push_back(mk(FN_RETURNED, 8'($urandom_range(0, 255)), 0));
			if (dl <= MAX_PAYLOAD)
				seq.push_back(mk(FN_RETURNED, st, 0));
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4))
					seq.push_back(mk(FN_RETURNED, 8'($urandom_range(0, 255)), 0));
			seq[seq.size()-1].lst = 1;
			// replay the same frame to walk the resend count up
			reps = $urandom_range(1, 3);
			n = seq.size();
			for (int r = 1; r < reps; r++)
				for (int i = 0; i < n; i++)
					seq.push_back(seq[i]);
		end else if (sel < 85) begin
			seq.push_back(mk(3'($urandom_range(FN_NEW_TOKEN, FN_STOP)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		end else if (sel < 92) begin
			// broken sequence: payload bytes, a stray command, closed as a token
			repeat ($urandom_range(1, 5))
				seq.push_back(mk(FN_DATA_IND, 8'($urandom_range(0, 255)), 0));
			seq.push_back(mk(($urandom_range(0, 1)) ? FN_START : FN_SPARE_A,
				8'($urandom_range(0, 255)), 0));
			seq.push_back(mk(FN_TOKEN, 8'($urandom_range(0, 255)), 1));
		end else begin
			seq.push_back(mk(($urandom_range(0, 1)) ? FN_SPARE_A : FN_SPARE_B,
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		end
		foreach (seq[i]) begin
			send(seq[i]);
			if (seq[i].fn != FN_SPARE_A && seq[i].fn != FN_SPARE_B)
				cnt++;
		end
	endtask

	row_t plan [] = '{
		'{'{FN_NEW_TOKEN, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b1, KIND_BYTE, 8'hFF},
		'{'{FN_START, 8'h00, 4'h0, 3'd0, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_NEW_TOKEN, 8'hFF, 4'hF, 3'd7, 1'b1}, 1'b1, KIND_BYTE, 8'hFF},
		'{'{FN_STOP, 8'h00, 4'h0, 3'd0, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_SPARE_A, 8'hFF, 4'hF, 3'd7, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_SPARE_B, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'h41, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'hFF, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'h7F, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'h01, 4'hF, 3'd7, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_DATA_IND, 8'h80, 4'h0, 3'd0, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_TOKEN, 8'hFF, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_TOKEN, 8'hFF, 4'h0, 3'd0, 1'b1}, 1'b1, KIND_CHANGE, 8'h00},
		'{'{FN_TOKEN, 8'hFF, 4'h0, 3'd0, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h78, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h01, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h55, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h00, 4'h0, 3'd0, 1'b1}, 1'b1, KIND_BYTE, 8'hFF},
		'{'{FN_RETURNED, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'h00, 4'h0, 3'd0, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_RETURNED, 8'hC8, 4'h0, 3'd0, 1'b1}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_START, 8'hFF, 4'hF, 3'd7, 1'b0}, 1'b0, KIND_BYTE, 8'h00},
		'{'{FN_NEW_TOKEN, 8'h00, 4'h0, 3'd0, 1'b1}, 1'b1, KIND_BYTE, 8'hFF}
	};

	// result checker
	always @(posedge clk) begin
		txres_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				report("result with nothing pending", out_byte, 0);
			end else begin
				want = awaited.pop_front();
				if (out_kind !== want.kind)
					report("out_kind", out_kind, want.kind);
				if (out_byte !== want.data)
					report("out_byte", out_byte, want.data);
				if (out_last !== want.fin)
					report("out_last", out_last, want.fin);
			end
		end
	end

	// receiver back-pressure
	initial begin
		forever begin
			@(posedge clk);
			if (squeeze) begin
				out_stall <= 1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze = 0;
				out_stall <= 0;
			end else if ($urandom_range(0, 99) < stall_pct / 10) begin
				out_stall <= 1;
				repeat ($urandom_range(5, 30)) @(posedge clk);
				out_stall <= 0;
			end else begin
				out_stall <= $urandom_range(0, 99) < stall_pct;
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int got, total;
		own_addr = 4'd1;
		tok_tag = 8'hFF;
		time_bit = 3'd3;
		foreach (svc_list[i])
			svc_list[i] = 8'h00;
		chat_on = 0;
		list_dirty = 0;
		text_done = 0;
		resends = 0;
		q_head = 0;
		q_tail = 0;
		q_fill = 0;
		byte_pos = 0;
		csum = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (plan[r]) begin
			send(plan[r].it);
			if (plan[r].typed && (fresh.size() == 0 || fresh[0].kind != plan[r].wkind
					|| fresh[0].data != plan[r].wbyte))
				report("directed first result", fresh.size() ? fresh[0].data : -1,
					plan[r].wbyte);
		end

		for (int ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(CFG_STATION_ADDRESS, 8'd0);
					write_reg(CFG_TOKEN_TAG, 8'h00);
					write_reg(CFG_TIME_SERVICE, 8'd0);
				end
				1: begin
					write_reg(CFG_STATION_ADDRESS, 8'd14);
					write_reg(CFG_TOKEN_TAG, 8'hFF);
					write_reg(CFG_TIME_SERVICE, 8'd7);
				end
				2: begin
					// own address off the end of the service list
					write_reg(CFG_STATION_ADDRESS, 8'd15);
					write_reg(CFG_TOKEN_TAG, 8'($urandom_range(0, 255)));
				end
				default: begin
					write_reg(CFG_STATION_ADDRESS, 8'($urandom_range(0, 14)));
					write_reg(CFG_TOKEN_TAG, 8'($urandom_range(0, 255)));
					write_reg(CFG_TIME_SERVICE, 8'($urandom_range(0, 7)));
				end
			endcase
			gap_pct = (ph == 3) ? 0 : 30;
			stall_pct = (ph == 4) ? 0 : 30;
			if (ph == 1)
				squeeze = 1;
			total = 0;
			while (total < PHASE_ITEMS) begin
				random_event(got);
				total += got;
			end
		end

		in_valid <= 0;
		while (awaited.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/trms_pkg.sv
src/trms_ram.sv
src/token_ring_mac_sender_top.sv
verif/testbench.sv
